@@ src/fsmap_pkg.sv @@
// shared types and constants for the free space map
`default_nettype none
package fsmap_pkg;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic        func;
        logic [9:0]  page_number;
        logic [12:0] amount;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [9:0] found_page;
    } t_out_item;

    typedef struct packed {
        logic    load;
        logic    div_step;
        logic    wr_entry;
        logic    scan_start;
        logic    scan_step;
        logic    clr_step;
        logic    finish;
        t_status fin_status;
    } t_cmd;

    typedef struct packed {
        logic range_err;
        logic is_query;
        logic scan_hit;
        logic scan_zero;
        logic scan_end;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

@@ src/fsmap_ram.sv @@
// generic single write port, single read port ram with registered read
`default_nettype none
module fsmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ src/fsmap_ctrl.sv @@
// controller state machine: clear sweep, divide, scan and result sequencing
`default_nettype none
module fsmap_ctrl
    import fsmap_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_fin_status;
    t_status n_fin_status;

    always_comb begin
        n_state          = r_state;
        n_fin_status     = r_fin_status;
        o_cmd            = '0;
        o_cmd.fin_status = r_fin_status;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.range_err) begin
                        n_fin_status = ST_RANGE;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.is_query) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_fin_status = ST_OK;
                    n_state      = S_DONE;
                end
            end
            S_SCAN: begin
                priority if (i_sts.scan_zero) begin
                    n_fin_status = ST_NONE;
                    n_state      = S_DONE;
                end else if (i_sts.scan_hit) begin
                    n_fin_status = ST_OK;
                    n_state      = S_DONE;
                end else if (i_sts.scan_end) begin
                    n_fin_status = ST_NONE;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.wr_entry = (r_fin_status == ST_OK) && !i_sts.is_query;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_fin_status <= ST_OK;
        end else begin
            r_state      <= n_state;
            r_fin_status <= n_fin_status;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

@@ src/fsmap_dp.sv @@
// datapath: range check, quantizing reciprocal multiply, table ram, scan and output register
`default_nettype none
module fsmap_dp
    import fsmap_pkg::*;
#(
    parameter int ENTRIES      = 1024,
    parameter int PAGE_BYTES   = 4096,
    parameter int FRACTION_MAX = 255
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_cmd,
    input  wire t_in_item  i_in_item,
    output t_sts           o_sts,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    localparam int AW  = $clog2(ENTRIES);
    localparam int IW  = AW + 1;
    localparam int RW  = 21;
    localparam int QL  = $clog2(PAGE_BYTES);
    localparam int QS  = RW + QL;
    localparam int MW  = RW + 2;
    localparam int PW  = RW + MW;
    // rounded-up reciprocal, exact floor for every RW-bit dividend
    localparam longint unsigned QM =
        ((64'd1 << QS) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);

    logic              r_func;
    logic [9:0]        r_page;
    logic [RW-1:0]     r_rem;
    logic [7:0]        r_q;
    logic [IW-1:0]     r_rd_idx;
    logic              r_chk_valid;
    logic [AW-1:0]     r_chk_idx;
    logic [AW-1:0]     r_clr_idx;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [PW-1:0]     quot_wide;
    logic [7:0]        cur;
    logic              fits;
    logic              rd_more;
    logic [AW+9:0]     page_wide;
    logic [AW+9:0]     found_wide;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;

    assign quot_wide = PW'(r_rem) * PW'(QM);
    assign fits      = ({1'b0, cur} + {1'b0, r_q}) < 9'(FRACTION_MAX);
    assign rd_more   = (r_rd_idx != IW'(ENTRIES));
    assign page_wide  = {{AW{1'b0}}, r_page};
    assign found_wide = {10'b0, r_chk_idx};

    assign o_sts.range_err = ({19'b0, i_in_item.amount} > 32'(PAGE_BYTES))
                          || ((i_in_item.func == FUNC_UPDATE)
                              && ({22'b0, i_in_item.page_number} >= 32'(ENTRIES)));
    assign o_sts.is_query  = (r_func == FUNC_QUERY);
    assign o_sts.scan_zero = r_chk_valid && (cur == 8'd0);
    assign o_sts.scan_hit  = r_chk_valid && (cur != 8'd0) && fits;
    assign o_sts.scan_end  = !r_chk_valid && !rd_more;
    assign o_sts.clr_last  = (r_clr_idx == AW'(ENTRIES - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign ram_we    = i_cmd.clr_step || i_cmd.wr_entry;
    assign ram_waddr = i_cmd.clr_step ? r_clr_idx : page_wide[AW-1:0];
    assign ram_wdata = i_cmd.clr_step ? 8'd0 : r_q;
    assign ram_re    = i_cmd.scan_step && rd_more;

    fsmap_ram #(
        .WIDTH(8),
        .DEPTH(ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_rd_idx[AW-1:0]),
        .o_rdata(cur)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_in_item.func;
            r_page <= i_in_item.page_number;
            r_rem  <= RW'(i_in_item.amount) * RW'(FRACTION_MAX);
            r_q    <= 8'd0;
        end else if (i_cmd.div_step) begin
            r_q <= 8'(quot_wide >> QS);
        end
        if (i_cmd.scan_step && rd_more) begin
            r_chk_idx <= r_rd_idx[AW-1:0];
        end
        if (i_cmd.finish) begin
            r_out.status     <= i_cmd.fin_status;
            r_out.found_page <= ((i_cmd.fin_status == ST_OK) && (r_func == FUNC_QUERY))
                                ? found_wide[9:0] : 10'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_chk_valid <= 1'b0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_rd_idx    <= IW'(1);
                r_chk_valid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (rd_more) begin
                    r_rd_idx <= r_rd_idx + IW'(1);
                end
                r_chk_valid <= rd_more;
            end
            if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

@@ src/free_space_map_top.sv @@
// top level of the free space map: controller, datapath and table ram
// update: divide, then done state, then output register; quantizing is a reciprocal multiply
// query: the scan reads one table entry per cycle from the ram port
// out of range item: straight from idle to the done state, then into the output register
// one item in work at a time; the next input is taken while a result waits in the output register
// reset (synchronous, active low) starts a clearing sweep of all table entries with no input taken
`default_nettype none
module free_space_map_top
    import fsmap_pkg::*;
#(
    parameter int ENTRIES      = 1024,
    parameter int PAGE_BYTES   = 4096,
    parameter int FRACTION_MAX = 255
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_item
);

    t_cmd cmd;
    t_sts sts;

    fsmap_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    fsmap_dp #(
        .ENTRIES     (ENTRIES),
        .PAGE_BYTES  (PAGE_BYTES),
        .FRACTION_MAX(FRACTION_MAX)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_sts      (sts),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

endmodule
`default_nettype wire

@@ src/fsmap_checker.sv @@
// port-level checker for the free space map and its bind to the top level
`default_nettype none
module fsmap_checker
    import fsmap_pkg::*;
#(
    parameter int PAGE_BYTES = 4096
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire t_in_item  i_in_item,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_item))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_item.status == ST_OK || i_out_item.status == ST_NONE
                         || i_out_item.status == ST_RANGE))
        else $error("undefined status code");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_item.status != ST_OK) |-> (i_out_item.found_page == 10'd0))
        else $error("page reported without success");

    a_range_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && ({19'b0, i_in_item.amount} > 32'(PAGE_BYTES))
        && !(i_out_valid && !i_out_ready)
        |=> ##1 (i_out_valid && (i_out_item.status == ST_RANGE)))
        else $error("oversize amount not flagged");

endmodule

bind free_space_map_top fsmap_checker #(
    .PAGE_BYTES(PAGE_BYTES)
) u_fsmap_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .i_in_ready (o_in_ready),
    .i_in_item  (i_in_item),
    .i_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .i_out_item (o_out_item)
);
`default_nettype wire

@@ dv/free_space_map_checker.sv @@
// free space map checker: predicts each response from the input transfers and compares results
module free_space_map_checker
    import fsmap_pkg::*;
#(
    parameter int ENTRIES      = 1024,
    parameter int PAGE_BYTES   = 4096,
    parameter int FRACTION_MAX = 255
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_item i_out_item,
    output int             o_errors,
    output int             o_pending
);

    logic [7:0] page_fraction [ENTRIES];
    t_out_item  awaited_responses [$];
    int         fail_count = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic logic [7:0] fraction_of(input logic [12:0] bytes);
        logic [31:0] scaled;
        scaled = {19'd0, bytes};
        scaled = (scaled * FRACTION_MAX) / PAGE_BYTES;
        return scaled[7:0];
    endfunction

    // applies one request to the shadow table and returns the response it should give
    function automatic t_out_item map_response(input t_in_item item);
        t_out_item  resp;
        logic [7:0] need;
        resp.status     = ST_OK;
        resp.found_page = '0;
        need = fraction_of(item.amount);
        if (item.amount > PAGE_BYTES) begin
            resp.status = ST_RANGE;
        end else if (item.func == FUNC_UPDATE) begin
            if (item.page_number >= ENTRIES) begin
                resp.status = ST_RANGE;
            end else begin
                page_fraction[item.page_number] = need;
            end
        end else begin
            resp.status = ST_NONE;
            // entry 0 is reserved, a zero entry ends the scan
            for (int i = 1; i < ENTRIES; i++) begin
                if (page_fraction[i] == 8'd0) begin
                    break;
                end
                if (page_fraction[i] + need < FRACTION_MAX) begin
                    resp.status     = ST_OK;
                    resp.found_page = i[9:0];
                    break;
                end
            end
        end
        return resp;
    endfunction

    task automatic check_response(input t_out_item got);
        t_out_item want;
        if (awaited_responses.size() == 0) begin
            $error("result with none awaited: status %0d found_page %0d",
                   got.status, got.found_page);
            fail_count++;
        end else begin
            want = awaited_responses.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                fail_count++;
            end
            if (got.found_page !== want.found_page) begin
                $error("found_page: expected %0d, actual %0d",
                       want.found_page, got.found_page);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (page_fraction[k]) page_fraction[k] = 8'd0;
            awaited_responses.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_response(i_out_item);
            end
            if (i_in_valid && i_in_ready) begin
                awaited_responses.push_back(map_response(i_in_item));
            end
            o_pending <= awaited_responses.size();
        end
        o_errors <= fail_count;
    end

endmodule

@@ dv/free_space_map_top_tb.sv @@
// free space map testbench: directed and random updates and queries with random idling
module free_space_map_top_tb;
    import fsmap_pkg::*;

    localparam int ENTRIES      = 1024;
    localparam int PAGE_BYTES   = 4096;
    localparam int FRACTION_MAX = 255;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;
    int        check_errors;
    int        check_pending;
    int        tx_idle_pct = 27;
    int        rx_idle_pct = 54;

    free_space_map_top #(
        .ENTRIES     (ENTRIES),
        .PAGE_BYTES  (PAGE_BYTES),
        .FRACTION_MAX(FRACTION_MAX)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    free_space_map_checker #(
        .ENTRIES     (ENTRIES),
        .PAGE_BYTES  (PAGE_BYTES),
        .FRACTION_MAX(FRACTION_MAX)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_item  (in_item),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_item (out_item),
        .o_errors   (check_errors),
        .o_pending  (check_pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic t_in_item make_request(input logic func, input int page,
                                              input int amount);
        t_in_item    item;
        logic [31:0] page_bits;
        logic [31:0] amount_bits;
        page_bits        = page;
        amount_bits      = amount;
        item.func        = func;
        item.page_number = page_bits[9:0];
        item.amount      = amount_bits[12:0];
        return item;
    endfunction

    function automatic int random_amount();
        int unsigned pick;
        pick = $urandom_range(9);
        case (pick)
            0: begin
                return $urandom_range(16);
            end
            1: begin
                return PAGE_BYTES;
            end
            2: begin
                return $urandom_range(8191);
            end
            default: begin
                return $urandom_range(PAGE_BYTES);
            end
        endcase
    endfunction

    // mostly updates near the bottom of the table so that queries scan a real prefix
    function automatic t_in_item random_request();
        int unsigned pick;
        logic [31:0] bits;
        pick = $urandom_range(99);
        if (pick < 45) begin
            return make_request(FUNC_UPDATE, $urandom_range(40, 1), random_amount());
        end else if (pick < 55) begin
            return make_request(FUNC_UPDATE, $urandom_range(ENTRIES - 1), random_amount());
        end else if (pick < 88) begin
            return make_request(FUNC_QUERY, $urandom_range(ENTRIES - 1), random_amount());
        end else begin
            bits = $urandom;
            return bits[23:0];
        end
    endfunction

    task automatic send(input t_in_item item);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            send(random_request());
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (check_pending != 0) @(posedge clk);
    endtask

    initial begin
        #20_000_000;
        $display("free_space_map_top_tb: errors");
        $finish;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, reserved entry, zero entry, full amount and range cases
        send(make_request(FUNC_QUERY, 0, 0));
        send(make_request(FUNC_UPDATE, 0, PAGE_BYTES));
        send(make_request(FUNC_QUERY, 0, 0));
        send(make_request(FUNC_UPDATE, 1, PAGE_BYTES));
        send(make_request(FUNC_UPDATE, 2, 0));
        send(make_request(FUNC_QUERY, 0, 0));
        send(make_request(FUNC_UPDATE, 2, PAGE_BYTES / 2));
        send(make_request(FUNC_QUERY, 0, PAGE_BYTES / 2));
        send(make_request(FUNC_QUERY, 0, 2064));
        send(make_request(FUNC_UPDATE, 3, 16));
        send(make_request(FUNC_UPDATE, 3, 17));
        send(make_request(FUNC_QUERY, 0, PAGE_BYTES));
        send(make_request(FUNC_QUERY, 0, PAGE_BYTES + 1));
        send(make_request(FUNC_UPDATE, 5, 8191));
        send(make_request(FUNC_UPDATE, ENTRIES - 1, PAGE_BYTES));
        send(make_request(FUNC_QUERY, 0, 8191));
        send(make_request(FUNC_QUERY, ENTRIES - 1, 0));
        send(make_request(FUNC_UPDATE, 1, 0));
        send(make_request(FUNC_QUERY, 0, 0));
        send(make_request(FUNC_UPDATE, 512, PAGE_BYTES - 1));
        send(make_request(FUNC_UPDATE, 1, 1));
        send(make_request(FUNC_QUERY, 0, 1));
        run_random(160);
        wait_drained();

        tx_idle_pct = 54;
        rx_idle_pct = 27;
        run_random(160);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(100);

        // fill the low part of the table so that scans run a long prefix
        for (int p = 1; p < ENTRIES / 8; p++) begin
            send(make_request(FUNC_UPDATE, p, PAGE_BYTES));
        end
        send(make_request(FUNC_QUERY, 0, 0));
        send(make_request(FUNC_UPDATE, 100, PAGE_BYTES / 2));
        send(make_request(FUNC_QUERY, 0, PAGE_BYTES / 4));
        send(make_request(FUNC_UPDATE, 100, PAGE_BYTES));
        send(make_request(FUNC_UPDATE, ENTRIES - 1, PAGE_BYTES / 2));
        send(make_request(FUNC_QUERY, 0, PAGE_BYTES / 4));
        send(make_request(FUNC_QUERY, 0, PAGE_BYTES));
        send(make_request(FUNC_QUERY, 0, 0));
        for (int n = 0; n < 6; n++) begin
            send(make_request(FUNC_QUERY, $urandom_range(ENTRIES - 1), random_amount()));
        end
        wait_drained();
        repeat (ENTRIES + 16) @(posedge clk);

        if (check_errors == 0 && check_pending == 0) begin
            $display("free_space_map_top_tb: clean");
        end else begin
            $display("free_space_map_top_tb: errors");
        end
        $finish;
    end

endmodule
